### hw/rtl/tdu_pkg.sv
`timescale 1ns / 1ps
package tdu_pkg;

    localparam int ROW_COUNT      = 24;
    localparam int COLS           = 40;
    localparam int ROW0_FIRST_COL = 8;
    localparam int SPLIT_ROW      = 13;

    localparam logic [7:0] TEXT_UNIT_ID = 8'h02;
    localparam logic [7:0] UNIT_LEN     = 8'h2C;
    localparam logic [7:0] FRAMING      = 8'hE4;
    localparam logic [7:0] STUFF_BYTE   = 8'hFF;
    localparam logic [7:0] PAR_OFF_BASE = 8'hC0;
    localparam logic [4:0] OFFSET_MASK  = 5'h1F;

    // bytes per data unit kind
    localparam logic [5:0] LEN_STUFF    = 6'd46;
    localparam logic [5:0] LEN_ROW0     = 6'd15;
    localparam logic [5:0] LEN_ROWN     = 6'd7;
    localparam logic [5:0] LEN_CHAR     = 6'd1;
    localparam logic [5:0] LEN_NONE     = 6'd0;

    typedef enum logic [1:0] {
        CFG_MAGAZINE = 2'd0,
        CFG_PAGE     = 2'd1,
        CFG_SUBCODE  = 2'd2,
        CFG_CONTROL  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic       mode;
        logic [4:0] row;
        logic [5:0] column;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [7:0] odd_par(input logic [7:0] c);
        return {~(^c[6:0]), c[6:0]};
    endfunction

    // hamming 8/4, already in transmission order
    function automatic logic [7:0] ham(input logic [3:0] nib);
        logic [7:0] h;
        case (nib)
            4'h0:    h = 8'h15;
            4'h1:    h = 8'h02;
            4'h2:    h = 8'h49;
            4'h3:    h = 8'h5E;
            4'h4:    h = 8'h64;
            4'h5:    h = 8'h73;
            4'h6:    h = 8'h38;
            4'h7:    h = 8'h2F;
            4'h8:    h = 8'hD0;
            4'h9:    h = 8'hC7;
            4'hA:    h = 8'h8C;
            4'hB:    h = 8'h9B;
            4'hC:    h = 8'hA1;
            4'hD:    h = 8'hB6;
            4'hE:    h = 8'hFD;
            default: h = 8'hEA;
        endcase
        return rev8(h);
    endfunction

endpackage

### hw/rtl/teletext_data_unit_encoder_unit.sv
`timescale 1ns / 1ps
// Teletext data-unit encoder. Each accepted input (one page character tagged with row and
// column, or a stuffing request) is held in an input register and expands into 0 to 46
// output bytes, one per cycle unless the output stalls, through a result register that
// decouples the output side. A plain character yields one byte, a row's first character 7
// (15 for row 0), a stuffing unit 46; the byte sequencer over the held item counts them out,
// and the next input is taken in the same cycle the last byte of the current one moves out.
// Inputs that produce nothing (row 0 columns below 8, rows or columns out of range) retire
// with no byte. Configuration writes take effect at once and are always accepted.
module teletext_data_unit_encoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tdu_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tdu_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [12:0]       i_cfg_data
);
    import tdu_pkg::*;

    logic [2:0]  r_magazine;
    logic [7:0]  r_page;
    logic [12:0] r_subcode;
    logic [10:0] r_control;

    logic        r_cur_valid;
    t_in_item    r_cur;
    logic [5:0]  r_idx;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        out_load;
    logic        is_start;
    logic [5:0]  len;
    logic        last;
    logic        done;
    logic        emit;
    logic [7:0]  par_off;
    logic [7:0]  hdr_byte;
    logic [7:0]  cur_byte;
    logic [4:0]  offset;
    logic [5:0]  n_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magazine <= 3'd1;
            r_page     <= 8'd0;
            r_subcode  <= 13'd0;
            r_control  <= 11'h090;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAGAZINE: r_magazine <= i_cfg_data[2:0];
                CFG_PAGE:     r_page     <= i_cfg_data[7:0];
                CFG_SUBCODE:  r_subcode  <= i_cfg_data;
                CFG_CONTROL:  r_control  <= i_cfg_data[10:0];
                default:      r_magazine <= r_magazine;
            endcase
        end
    end

    // classify the held item
    always_comb begin
        is_start = ((r_cur.row == 5'd0) && (r_cur.column == 6'(ROW0_FIRST_COL))) ||
                   ((r_cur.row != 5'd0) && (r_cur.column == 6'd0));
        if (r_cur.mode) begin
            len = LEN_STUFF;
        end else if ((r_cur.row >= 5'(ROW_COUNT)) || (r_cur.column >= 6'(COLS)) ||
                     ((r_cur.row == 5'd0) && (r_cur.column < 6'(ROW0_FIRST_COL)))) begin
            len = LEN_NONE;
        end else if (is_start && (r_cur.row == 5'd0)) begin
            len = LEN_ROW0;
        end else if (is_start) begin
            len = LEN_ROWN;
        end else begin
            len = LEN_CHAR;
        end
    end

    always_comb begin
        if (r_cur.row < 5'(SPLIT_ROW)) begin
            offset  = r_cur.row + 5'd7;
            par_off = PAR_OFF_BASE | 8'h20 | {3'd0, offset & OFFSET_MASK};
        end else begin
            offset  = r_cur.row - 5'd5;
            par_off = PAR_OFF_BASE | {3'd0, offset & OFFSET_MASK};
        end
    end

    always_comb begin
        case (r_idx[3:0])
            4'd0:    hdr_byte = TEXT_UNIT_ID;
            4'd1:    hdr_byte = UNIT_LEN;
            4'd2:    hdr_byte = par_off;
            4'd3:    hdr_byte = FRAMING;
            4'd4:    hdr_byte = ham({r_cur.row[0], r_magazine});
            4'd5:    hdr_byte = ham(r_cur.row[4:1]);
            4'd6:    hdr_byte = ham(r_page[3:0]);
            4'd7:    hdr_byte = ham(r_page[7:4]);
            4'd8:    hdr_byte = ham(r_subcode[3:0]);
            4'd9:    hdr_byte = ham({r_control[0], r_subcode[6:4]});
            4'd10:   hdr_byte = ham(r_subcode[10:7]);
            4'd11:   hdr_byte = ham({r_control[2:1], r_subcode[12:11]});
            4'd12:   hdr_byte = ham(r_control[6:3]);
            default: hdr_byte = ham(r_control[10:7]);
        endcase
    end

    always_comb begin
        if (r_cur.mode) begin
            cur_byte = (r_idx == 6'd1) ? UNIT_LEN : STUFF_BYTE;
        end else if (r_idx < (len - 6'd1)) begin
            cur_byte = hdr_byte;
        end else begin
            cur_byte = rev8(odd_par(r_cur.char_code));
        end
    end

    assign out_load   = !r_out_valid || i_out_ready;
    assign last       = (r_idx == (len - 6'd1));
    assign emit       = r_cur_valid && (len != LEN_NONE) && out_load;
    assign done       = r_cur_valid && ((len == LEN_NONE) || (out_load && last));
    assign o_in_ready = !r_cur_valid || done;

    always_comb begin
        n_idx = r_idx;
        if (done) begin
            n_idx = 6'd0;
        end else if (emit) begin
            n_idx = r_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (o_in_ready) begin
                r_cur_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cur <= i_in_data;
        end
        if (emit) begin
            r_out.out_byte    <= cur_byte;
            r_out.last_of_run <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer never runs past the length of the held item
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid && (len != LEN_NONE) |-> r_idx < len)
        else $error("byte index beyond data unit length");

    // a new transfer in while an item is held only when that item retires
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && r_cur_valid |-> done)
        else $error("held item replaced before its last byte");

    // index restarts after a retired item
    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_idx == 6'd0)
        else $error("byte index not cleared after last byte");

endmodule
